FILE: sv/rsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types and constants of the record stream deframer.
// ----------------------------------------------------------------------------
package rsd_pkg;

  localparam int LEN_W      = 17;
  localparam int SUM_W      = 18;
  localparam int HDR_BYTES  = 16;
  localparam int COUNT_W    = 13;
  localparam int FIFO_DEPTH = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    KIND_HEADER    = 2'd0,
    KIND_DATA      = 2'd1,
    KIND_END       = 2'd2,
    KIND_MALFORMED = 2'd3
  } kind_t;

  typedef enum logic {
    PH_HEADER = 1'b0,
    PH_DATA   = 1'b1
  } phase_t;

  typedef struct packed {
    kind_t               kind;
    logic [63:0]         expiration;
    logic [15:0]         payload_len;
    logic [15:0]         record_flags;
    logic [31:0]         type_num;
    logic [7:0]          data_byte;
    logic [COUNT_W-1:0]  record_count;
    logic                ends_record;
    logic                last_of_run;
  } result_t;

  localparam result_t RESULT_ZERO = '0;

  // results produced by one accepted byte
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

FILE: sv/record_stream_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_stream_deframer_top
// Parses a serialized record buffer fed one byte per transfer.
//
// Input channel (in_valid/in_ready) carries one buffer byte per transfer;
// in_first_byte marks the first byte of a buffer and restarts the parse.
// cfg_wr_en/cfg_wr_data load the buffer length; the user is to write it between buffers, the block does not enforce it.
// Output channel (out_valid/out_ready) gives decoded headers, data bytes,
// an end result with the record count, or a malformed result.
// Results are registered in the result queue when the byte that causes them is accepted.
// Takes one byte per cycle while in_ready is high; each byte gives zero, one
// or two results and the four-entry result queue delivers one per cycle while
// the receiver is ready, so a byte that gives two results needs two transfers.
// in_ready is high while the queue has at least two free entries; a stalled
// receiver fills the queue and then holds off the input, nothing is lost.
// After reset the length is zero and bytes are ignored until a first byte.
// ----------------------------------------------------------------------------
module record_stream_deframer_top import rsd_pkg::*; #(
  parameter int MAX_BUFFER = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [LEN_W-1:0]    cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte_value,
  input  logic                in_first_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [63:0]         out_expiration,
  output logic [15:0]         out_payload_len,
  output logic [15:0]         out_record_flags,
  output logic [31:0]         out_type_num,
  output logic [7:0]          out_data_byte,
  output logic [COUNT_W-1:0]  out_record_count,
  output logic                out_ends_record,
  output logic                out_last_of_run
);

  logic [LEN_W-1:0] buffer_length_r;
  push_t            push;
  result_t          res;
  logic             room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_length_r <= '0;
    end else if (cfg_wr_en) begin
      buffer_length_r <= cfg_wr_data;
    end
  end

  assign in_ready = room;

  rsd_core #(
    .MAX_BUFFER(MAX_BUFFER)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .buffer_length(buffer_length_r),
    .in_fire      (in_valid && in_ready),
    .byte_value   (in_byte_value),
    .first_byte   (in_first_byte),
    .push         (push)
  );

  rsd_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (res)
  );

  assign out_kind         = res.kind;
  assign out_expiration   = res.expiration;
  assign out_payload_len  = res.payload_len;
  assign out_record_flags = res.record_flags;
  assign out_type_num     = res.type_num;
  assign out_data_byte    = res.data_byte;
  assign out_record_count = res.record_count;
  assign out_ends_record  = res.ends_record;
  assign out_last_of_run  = res.last_of_run;

endmodule

FILE: sv/rsd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_core
// Parse state and per-byte decode: produces up to two results per byte.
// ----------------------------------------------------------------------------
module rsd_core import rsd_pkg::*; #(
  parameter int MAX_BUFFER = 65536
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [LEN_W-1:0] buffer_length,
  input  logic             in_fire,
  input  logic [7:0]       byte_value,
  input  logic             first_byte,
  output push_t            push
);

  localparam int LEN_CAP = (MAX_BUFFER < (2 ** LEN_W) - 1) ? MAX_BUFFER : (2 ** LEN_W) - 1;
  localparam int OFS_W   = $clog2(LEN_CAP + 1);
  localparam logic [LEN_W-1:0] CAP_VAL = LEN_W'(LEN_CAP);

  logic [OFS_W-1:0]   offset_r, offset_nxt;
  phase_t             phase_r, phase_nxt;
  logic [3:0]         fill_r, fill_nxt;
  logic [15:0]        left_r, left_nxt;
  logic [COUNT_W-1:0] seen_r, seen_nxt;
  logic               finished_r, finished_nxt;
  logic [119:0]       hdr_r, hdr_nxt;

  logic [OFS_W-1:0]   offs, offs_inc;
  phase_t             phase;
  logic [3:0]         fill;
  logic [15:0]        left, left_dec;
  logic [COUNT_W-1:0] seen, seen_inc;
  logic               fin;
  logic               active;
  logic [LEN_W-1:0]   eff_len;
  logic               start_end, hdr_done, hdr_zero, overrun, tail_short, data_end;
  logic [127:0]       hdr;
  logic [15:0]        ds;

  // restart view of the state
  assign offs  = first_byte ? '0 : offset_r;
  assign phase = first_byte ? PH_HEADER : phase_r;
  assign fill  = first_byte ? '0 : fill_r;
  assign left  = first_byte ? '0 : left_r;
  assign seen  = first_byte ? '0 : seen_r;
  assign fin   = first_byte ? 1'b0 : finished_r;

  assign active  = in_fire && !fin;
  assign eff_len = (buffer_length > CAP_VAL) ? CAP_VAL : buffer_length;

  assign offs_inc = offs + OFS_W'(1);
  assign seen_inc = (seen == COUNT_MAX) ? seen : seen + COUNT_W'(1);
  assign left_dec = (left != '0) ? left - 16'd1 : '0;
  assign data_end = (left_dec == '0);

  assign hdr      = {hdr_r, byte_value};
  assign ds       = hdr[63:48];
  assign hdr_zero = (hdr == '0);

  assign start_end  = (fill == '0) &&
                      ((SUM_W'(offs) + SUM_W'(HDR_BYTES)) > SUM_W'(eff_len));
  assign hdr_done   = !start_end && (fill == 4'd15);
  assign overrun    = (SUM_W'(offs_inc) + SUM_W'(ds)) > SUM_W'(eff_len);
  assign tail_short = (SUM_W'(offs_inc) + SUM_W'(HDR_BYTES)) > SUM_W'(eff_len);

  // next state
  always_comb begin
    offset_nxt   = offset_r;
    phase_nxt    = phase_r;
    fill_nxt     = fill_r;
    left_nxt     = left_r;
    seen_nxt     = seen_r;
    finished_nxt = finished_r;
    hdr_nxt      = hdr_r;
    if (in_fire) begin
      offset_nxt   = offs;
      phase_nxt    = phase;
      fill_nxt     = fill;
      left_nxt     = left;
      seen_nxt     = seen;
      finished_nxt = fin;
    end
    if (active) begin
      unique case (phase)
        PH_HEADER: begin
          if (start_end) begin
            finished_nxt = 1'b1;
          end else begin
            hdr_nxt    = hdr[119:0];
            fill_nxt   = fill + 4'd1;
            offset_nxt = offs_inc;
            if (hdr_done) begin
              if (hdr_zero || overrun) begin
                finished_nxt = 1'b1;
              end else begin
                seen_nxt = seen_inc;
                if (ds == '0) begin
                  finished_nxt = tail_short;
                end else begin
                  phase_nxt = PH_DATA;
                  left_nxt  = ds;
                end
              end
            end
          end
        end
        PH_DATA: begin
          offset_nxt = offs_inc;
          left_nxt   = left_dec;
          if (data_end) begin
            phase_nxt    = PH_HEADER;
            fill_nxt     = '0;
            finished_nxt = tail_short;
          end
        end
      endcase
    end
  end

  // results
  always_comb begin
    push    = '0;
    push.r0 = RESULT_ZERO;
    push.r1 = RESULT_ZERO;
    if (active) begin
      unique case (phase)
        PH_HEADER: begin
          if (start_end) begin
            push.count           = 2'd1;
            push.r0.kind         = KIND_END;
            push.r0.record_count = seen;
          end else if (hdr_done) begin
            push.count = 2'd1;
            if (hdr_zero) begin
              push.r0.kind         = KIND_END;
              push.r0.record_count = seen;
            end else if (overrun) begin
              push.r0.kind = KIND_MALFORMED;
            end else begin
              push.r0.kind         = KIND_HEADER;
              push.r0.expiration   = hdr[127:64];
              push.r0.payload_len  = ds;
              push.r0.record_flags = hdr[47:32];
              push.r0.type_num     = hdr[31:0];
              push.r0.record_count = seen_inc;
              push.r0.ends_record  = (ds == '0);
              if ((ds == '0) && tail_short) begin
                push.count           = 2'd2;
                push.r1.kind         = KIND_END;
                push.r1.record_count = seen_inc;
              end
            end
          end
        end
        PH_DATA: begin
          push.count           = 2'd1;
          push.r0.kind         = KIND_DATA;
          push.r0.data_byte    = byte_value;
          push.r0.record_count = seen;
          push.r0.ends_record  = data_end;
          if (data_end && tail_short) begin
            push.count           = 2'd2;
            push.r1.kind         = KIND_END;
            push.r1.record_count = seen;
          end
        end
      endcase
    end
    push.r0.last_of_run = (push.count == 2'd1);
    push.r1.last_of_run = (push.count == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r   <= '0;
      phase_r    <= PH_HEADER;
      fill_r     <= '0;
      left_r     <= '0;
      seen_r     <= '0;
      finished_r <= 1'b1;
    end else begin
      offset_r   <= offset_nxt;
      phase_r    <= phase_nxt;
      fill_r     <= fill_nxt;
      left_r     <= left_nxt;
      seen_r     <= seen_nxt;
      finished_r <= finished_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

endmodule

FILE: sv/rsd_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_out_fifo
// Result queue: takes up to two results per cycle, gives one per transfer.
// ----------------------------------------------------------------------------
module rsd_out_fifo import rsd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  result_t            q_r [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PTR_W-1:0]   wr_ptr_1;
  logic               pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = q_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign room      = (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign wr_ptr_1  = wr_ptr_r + PTR_W'(1);

  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push.count);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign cnt_nxt    = cnt_r + CNT_W'(push.count) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q_r[wr_ptr_r] <= push.r0;
    end
    if (push.count == 2'd2) begin
      q_r[wr_ptr_1] <= push.r1;
    end
  end

endmodule

FILE: tb/sv/tb_record_stream_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_record_stream_deframer_top
// Self-checking bench for the record stream deframer.
//
// Builds serialized record buffers: records with random header fields and
// payload, closed by padding, by a short tail, by a header whose payload
// runs past the length, or cut off inside a record by the next buffer.
// The buffer length is loaded while the block is idle, now and then in the
// middle of a buffer. Bytes go in with random gaps while the receiver stalls
// at random. A scoreboard class parses every accepted byte on its own and
// compares each result transfer, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module tb_record_stream_deframer_top;
  import rsd_pkg::*;

  localparam int MAX_BUFFER    = 65536;
  localparam int ITEM_TARGET   = 800;
  localparam int SETTLE_CYCLES = 4;
  localparam int TIMEOUT_NS    = 4000000;

  class deframe_scoreboard;
    result_t            due_results[$];
    result_t            byte_results[$];
    int unsigned        mismatches;
    int unsigned        used_bytes;
    logic [LEN_W-1:0]   length_reg;
    int unsigned        offset;
    logic [7:0]         hdr [HDR_BYTES];
    phase_t             phase;
    int unsigned        data_left;
    logic [COUNT_W-1:0] records;
    bit                 done;
    int unsigned        fill;

    function new();
      mismatches = 0;
      used_bytes = 0;
      length_reg = '0;
      offset     = 0;
      phase      = PH_HEADER;
      data_left  = 0;
      records    = '0;
      done       = 1'b1;
      fill       = 0;
    endfunction

    function int unsigned usable_length();
      return (length_reg > MAX_BUFFER) ? MAX_BUFFER : length_reg;
    endfunction

    function result_t blank(kind_t k);
      result_t r;
      r = RESULT_ZERO;
      r.kind = k;
      r.record_count = records;
      return r;
    endfunction

    // end of records when less than a header is left
    function bit close_if_short();
      if (offset + HDR_BYTES <= usable_length()) return 1'b0;
      byte_results.push_back(blank(KIND_END));
      done = 1'b1;
      return 1'b1;
    endfunction

    function void parse_byte(logic [7:0] value, logic first);
      result_t     r;
      logic [15:0] payload;
      bit          all_zero;
      bit          dropped;
      byte_results.delete();
      dropped = 1'b0;
      if (first) begin
        offset    = 0;
        phase     = PH_HEADER;
        data_left = 0;
        records   = '0;
        fill      = 0;
        done      = 1'b0;
      end
      if (done) return;
      used_bytes++;
      if (phase != PH_DATA) begin
        if (fill == 0) dropped = close_if_short();
        if (!dropped) begin
          hdr[fill] = value;
          fill++;
          offset++;
          if (fill == HDR_BYTES) begin
            fill = 0;
            payload = {hdr[8], hdr[9]};
            all_zero = 1'b1;
            foreach (hdr[i]) if (hdr[i] != 8'h00) all_zero = 1'b0;
            if (all_zero) begin
              byte_results.push_back(blank(KIND_END));
              done = 1'b1;
            end else if (offset + payload > usable_length()) begin
              r = blank(KIND_MALFORMED);
              r.record_count = '0;
              byte_results.push_back(r);
              done = 1'b1;
            end else begin
              if (records != COUNT_MAX) records++;
              r = blank(KIND_HEADER);
              r.expiration   = {hdr[0], hdr[1], hdr[2], hdr[3],
                                hdr[4], hdr[5], hdr[6], hdr[7]};
              r.payload_len  = payload;
              r.record_flags = {hdr[10], hdr[11]};
              r.type_num     = {hdr[12], hdr[13], hdr[14], hdr[15]};
              r.ends_record  = (payload == 16'h0000);
              byte_results.push_back(r);
              if (payload == 16'h0000) begin
                void'(close_if_short());
              end else begin
                phase     = PH_DATA;
                data_left = payload;
              end
            end
          end
        end
      end else begin
        offset++;
        if (data_left > 0) data_left--;
        r = blank(KIND_DATA);
        r.data_byte   = value;
        r.ends_record = (data_left == 0);
        byte_results.push_back(r);
        if (data_left == 0) begin
          phase = PH_HEADER;
          fill  = 0;
          void'(close_if_short());
        end
      end
      if (byte_results.size() != 0) begin
        r = byte_results.pop_back();
        r.last_of_run = 1'b1;
        byte_results.push_back(r);
      end
      foreach (byte_results[i]) due_results.push_back(byte_results[i]);
    endfunction

    function string describe(result_t r);
      return $sformatf({"kind %0d exp %h size %h flags %h type %h byte %h ",
                        "count %0d ends %b last %b"},
                       r.kind, r.expiration, r.payload_len, r.record_flags, r.type_num,
                       r.data_byte, r.record_count, r.ends_record, r.last_of_run);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", describe(got));
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.expiration !== want.expiration ||
          got.payload_len !== want.payload_len || got.record_flags !== want.record_flags ||
          got.type_num !== want.type_num || got.data_byte !== want.data_byte ||
          got.record_count !== want.record_count || got.ends_record !== want.ends_record ||
          got.last_of_run !== want.last_of_run) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch expected: %s", describe(want));
          $display("         actual:   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               cfg_wr_en     = 1'b0;
  logic [LEN_W-1:0]   cfg_wr_data   = '0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [7:0]         in_byte_value = '0;
  logic               in_first_byte = 1'b0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic [1:0]         out_kind;
  logic [63:0]        out_expiration;
  logic [15:0]        out_payload_len;
  logic [15:0]        out_record_flags;
  logic [31:0]        out_type_num;
  logic [7:0]         out_data_byte;
  logic [COUNT_W-1:0] out_record_count;
  logic               out_ends_record;
  logic               out_last_of_run;

  deframe_scoreboard  sb = new();
  bit                 steady = 1'b0;
  int unsigned        ready_hold = 0;
  logic [7:0]         frame_q[$];
  int unsigned        record_marks[$];
  logic [LEN_W-1:0]   frame_len;

  always #1 clk = ~clk;

  record_stream_deframer_top #(
    .MAX_BUFFER(MAX_BUFFER)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_value    (in_byte_value),
    .in_first_byte    (in_first_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_expiration   (out_expiration),
    .out_payload_len  (out_payload_len),
    .out_record_flags (out_record_flags),
    .out_type_num     (out_type_num),
    .out_data_byte    (out_data_byte),
    .out_record_count (out_record_count),
    .out_ends_record  (out_ends_record),
    .out_last_of_run  (out_last_of_run)
  );

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    if (steady) begin
      out_ready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ready) begin
      out_ready  <= 1'b0;
      ready_hold <= pick_gap();
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 24);
    end
  end

  always @(posedge clk) begin : monitor
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.kind         = kind_t'(out_kind);
      got.expiration   = out_expiration;
      got.payload_len  = out_payload_len;
      got.record_flags = out_record_flags;
      got.type_num     = out_type_num;
      got.data_byte    = out_data_byte;
      got.record_count = out_record_count;
      got.ends_record  = out_ends_record;
      got.last_of_run  = out_last_of_run;
      sb.check_result(got);
    end
    if (rst_n && in_valid && in_ready) sb.parse_byte(in_byte_value, in_first_byte);
  end

  task automatic send_byte(input logic [7:0] value, input logic first);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte_value <= value;
    in_first_byte <= first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(input logic [LEN_W-1:0] len);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    sb.length_reg = len;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void add_header(logic [63:0] expiration, logic [15:0] payload,
                                     logic [15:0] flags, logic [31:0] rtype);
    logic [127:0] word;
    word = {expiration, payload, flags, rtype};
    for (int i = 15; i >= 0; i--) frame_q.push_back(word[i*8 +: 8]);
  endfunction

  function automatic logic [15:0] pick_payload();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 16'($urandom_range(0, 4));
    if (roll < 95) return 16'($urandom_range(5, 24));
    return 16'($urandom_range(25, 90));
  endfunction

  function automatic void plan_frame(int unsigned ending);
    int unsigned nrec;
    int unsigned body;
    int unsigned payload;
    frame_q.delete();
    record_marks.delete();
    nrec = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 4);
    repeat (nrec) begin
      record_marks.push_back(frame_q.size());
      payload = 32'(pick_payload());
      add_header({$urandom, $urandom}, 16'(payload), 16'($urandom), $urandom);
      repeat (payload) frame_q.push_back(8'($urandom));
    end
    body = frame_q.size();
    if (ending < 3) begin
      // padding header
      record_marks.push_back(body);
      repeat (HDR_BYTES) frame_q.push_back(8'h00);
      frame_len = LEN_W'(body + HDR_BYTES + $urandom_range(0, 40));
    end else if (ending < 6) begin
      frame_len = LEN_W'(body + $urandom_range(0, 15));
    end else if (ending < 8) begin
      // payload runs past the length, beyond the clamp or just past the end
      record_marks.push_back(body);
      if (ending == 6) begin
        frame_len = '1;
        payload = 65535;
      end else begin
        frame_len = LEN_W'(body + HDR_BYTES + $urandom_range(0, 30));
        payload = frame_len - body - HDR_BYTES + $urandom_range(1, 40);
      end
      add_header({$urandom, $urandom}, 16'(payload), 16'($urandom), $urandom);
    end else begin
      // cut inside a long record, the next buffer restarts the parse
      frame_len = LEN_W'((ending == 8) ? MAX_BUFFER : body + HDR_BYTES + 200);
      payload = frame_len - body - HDR_BYTES;
      record_marks.push_back(body);
      add_header({$urandom, $urandom}, 16'(payload), 16'($urandom), $urandom);
      repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom));
    end
    if (ending < 8) begin
      repeat ($urandom_range(frame_q.size() == 0 ? 1 : 0, 3)) frame_q.push_back(8'($urandom));
    end
  endfunction

  task automatic send_frame(input bit split);
    int unsigned cut;
    cut = frame_q.size();
    if (split && record_marks.size() != 0) begin
      cut = record_marks[$urandom_range(0, record_marks.size() - 1)];
    end
    for (int i = 0; i < frame_q.size(); i++) begin
      if (split && i == cut) begin
        wait_idle();
        set_length(LEN_W'(cut + $urandom_range(0, 24)));
      end
      send_byte(frame_q[i], i == 0);
    end
  endtask

  initial begin : stimulus
    int unsigned frame_no;
    int unsigned ending;
    frame_no = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // ignored until a first byte, then too short for any header
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    wait_idle();
    set_length('0);
    send_byte(8'hFF, 1'b1);
    wait_idle();
    set_length(LEN_W'(HDR_BYTES - 1));
    send_byte(8'h00, 1'b1);
    wait_idle();

    // one empty record filling the buffer: header and end on the same byte
    set_length(LEN_W'(HDR_BYTES));
    frame_q.delete();
    add_header('1, 16'h0000, '1, '1);
    frame_q.push_back(8'h3C);
    send_frame(1'b0);

    while (sb.used_bytes < ITEM_TARGET) begin
      wait_idle();
      steady = ($urandom_range(0, 4) == 0);
      if (frame_no < 2 || $urandom_range(0, 3) != 0) begin
        ending = (frame_no == 0) ? 6 : (frame_no == 1) ? 8 : $urandom_range(0, 9);
        plan_frame(ending);
        set_length(frame_len);
      end
      send_frame($urandom_range(0, 7) == 0);
      frame_no++;
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
